// ===== sv/bsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_pkg
// shared constants, command codes and row mask helpers for the draw engine
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int CANVAS_ROWS = 32;
    localparam int CANVAS_COLS = 32;
    localparam int ROW_AW      = $clog2(CANVAS_ROWS);

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_RECT    = 3'd1;
    localparam logic [2:0] OP_LINE    = 3'd2;
    localparam logic [2:0] OP_TRI     = 3'd3;
    localparam logic [2:0] OP_DISC    = 3'd4;
    localparam logic [2:0] OP_ERECT   = 3'd5;
    localparam logic [2:0] OP_EDISC   = 3'd6;
    localparam logic [2:0] OP_READ    = 3'd7;

    typedef logic [CANVAS_COLS-1:0] t_row;

    typedef struct packed {
        logic [2:0] func;
        logic [4:0] pos_row;
        logic [4:0] pos_col;
        logic [5:0] arg_a;
        logic [5:0] arg_b;
    } t_cmd;

    // mask of columns lo..hi inclusive (signed ends, clipped to canvas)
    function automatic t_row span_mask(input logic signed [8:0] lo,
                                       input logic signed [8:0] hi);
        t_row m;
        m = '0;
        for (int c = 0; c < CANVAS_COLS; c++) begin
            if ($signed(9'(c)) >= lo && $signed(9'(c)) <= hi) begin
                m[c] = 1'b1;
            end
        end
        return m;
    endfunction

    // single column bit, clipped
    function automatic t_row bit_mask(input logic signed [8:0] col);
        return span_mask(col, col);
    endfunction

endpackage

// ===== sv/bsd_row_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_row_gen
// per-row shape mask: given the command and a row index, which bits to set
// or clear in that row
// ----------------------------------------------------------------------------
module bsd_row_gen (
    input  bsd_pkg::t_cmd          i_cmd,
    input  logic [bsd_pkg::ROW_AW-1:0] i_row,
    input  logic [13:0]            i_dy2,
    output bsd_pkg::t_row          o_mask,
    output logic                   o_set
);
    logic signed [8:0] s_y, s_r, s_c, s_a, s_b, s_rend, s_cend;
    logic [13:0]       s_lim;
    bsd_pkg::t_row     s_disc_lt, s_disc_le;

    assign s_y    = $signed(9'(i_row));
    assign s_r    = $signed(9'(i_cmd.pos_row));
    assign s_c    = $signed(9'(i_cmd.pos_col));
    assign s_a    = $signed(9'(i_cmd.arg_a));
    assign s_b    = $signed(9'(i_cmd.arg_b));
    assign s_rend = s_r + s_a - 9'sd1;
    assign s_cend = s_c + s_b - 9'sd1;
    assign s_lim  = 14'(i_cmd.arg_a) * 14'(i_cmd.arg_a);

    // disc rows: per-column distance compare against radius squared
    always_comb begin
        logic signed [8:0] dx;
        logic [13:0]       d;
        s_disc_lt = '0;
        s_disc_le = '0;
        for (int c = 0; c < bsd_pkg::CANVAS_COLS; c++) begin
            dx = $signed(9'(c)) - s_c;
            d  = 14'(dx * dx) + i_dy2;
            s_disc_lt[c] = (d < s_lim);
            s_disc_le[c] = (d <= s_lim);
        end
    end

    always_comb begin
        logic signed [8:0] di;
        o_mask = '0;
        o_set  = 1'b1;
        di     = s_y - s_r;
        case (i_cmd.func)
            bsd_pkg::OP_RECT: begin
                if (i_cmd.arg_a != 6'd0 && i_cmd.arg_b != 6'd0) begin
                    if (s_y == s_r || s_y == s_rend) begin
                        o_mask = bsd_pkg::span_mask(s_c, s_cend);
                    end else if (s_y > s_r && s_y < s_rend) begin
                        o_mask = bsd_pkg::bit_mask(s_c) | bsd_pkg::bit_mask(s_cend);
                    end
                end
            end
            bsd_pkg::OP_LINE: begin
                if (s_r == s_a) begin
                    if (s_y == s_r) begin
                        o_mask = (s_c < s_b) ? bsd_pkg::span_mask(s_c, s_b)
                                             : bsd_pkg::span_mask(s_b, s_c);
                    end
                end else if (s_c == s_b) begin
                    if ((s_y >= s_r && s_y <= s_a) || (s_y >= s_a && s_y <= s_r)) begin
                        o_mask = bsd_pkg::bit_mask(s_c);
                    end
                end
            end
            bsd_pkg::OP_TRI: begin
                if (i_cmd.arg_a != 6'd0 && s_y >= s_r && s_y <= s_rend) begin
                    if (s_y == s_rend) begin
                        o_mask = bsd_pkg::span_mask(s_c - s_a + 9'sd1, s_rend - s_r + s_c);
                    end else begin
                        o_mask = bsd_pkg::bit_mask(s_c - di) | bsd_pkg::bit_mask(s_c + di);
                    end
                end
            end
            bsd_pkg::OP_DISC: begin
                o_mask = s_disc_lt;
            end
            bsd_pkg::OP_ERECT: begin
                o_set = 1'b0;
                if (s_y >= s_r && s_y <= s_rend) begin
                    o_mask = bsd_pkg::span_mask(s_c, s_cend);
                end
            end
            bsd_pkg::OP_EDISC: begin
                o_set  = 1'b0;
                o_mask = s_disc_le;
            end
            default: begin
                o_mask = '0;
            end
        endcase
    end
endmodule

// ===== sv/bitmap_shape_draw_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_shape_draw_engine_top
// one-bit-per-pixel canvas with shape drawing and row readback
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// exactly one result, shown for one cycle with o_done high; the receiver cannot
// stall it. The canvas is a 32x32 simple dual-port row memory (one read and one
// write port) with a registered read port. Shape and clear requests sweep every
// row, reading it, merging the row mask and writing it back one row per cycle.
// busy stays high through the row reads and the final write in ST_LAST, and the
// result shows once the engine is idle again, where the next request can already
// be taken. A read-row request passes through ST_RD and ST_RD2, shows its result
// in ST_RD2, and the next request can be taken in the cycle after that. After
// reset a clearing pass over every row holds busy high before the first request.
// Rows are swept in order, so read and write never hit the same row in flight:
// the row read in one cycle is written in the next while the following row is
// read.
// ----------------------------------------------------------------------------
module bitmap_shape_draw_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [4:0]  i_pos_row,
    input  logic [4:0]  i_pos_col,
    input  logic [5:0]  i_arg_a,
    input  logic [5:0]  i_arg_b,
    output logic        o_done,
    output logic [2:0]  o_done_op,
    output logic [31:0] o_row_pixels
);
    localparam int AW = bsd_pkg::ROW_AW;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_LAST  = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_RD2   = 3'd5;

    // canvas memory
    bsd_pkg::t_row     r_mem [bsd_pkg::CANVAS_ROWS];
    bsd_pkg::t_row     r_rdata;
    logic              s_we;
    logic [AW-1:0]     s_waddr, s_raddr;
    bsd_pkg::t_row     s_wdata;

    logic [2:0]        r_state, n_state;
    logic [AW:0]       r_cnt, n_cnt;
    logic [AW-1:0]     r_wrow;
    bsd_pkg::t_cmd     r_cmd;
    bsd_pkg::t_row     r_mask;
    logic              r_set;
    logic [13:0]       r_dy2;
    bsd_pkg::t_row     s_mask;
    logic              s_set;
    logic signed [8:0] s_dy;
    logic              r_done;
    logic [2:0]        r_done_op;
    logic [31:0]       r_pix;

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_waddr] <= s_wdata;
        end
        r_rdata <= r_mem[s_raddr];
    end

    // mask for the row being read this cycle, used when its data returns
    bsd_row_gen u_gen (
        .i_cmd  (r_cmd),
        .i_row  (r_cnt[AW-1:0]),
        .i_dy2  (r_dy2),
        .o_mask (s_mask),
        .o_set  (s_set)
    );

    assign s_dy    = $signed(9'(r_cnt[AW-1:0])) - $signed(9'(r_cmd.pos_row));
    assign busy    = (r_state != ST_IDLE);
    assign s_raddr = (r_state == ST_IDLE) ? i_pos_row[AW-1:0] : r_cnt[AW-1:0];

    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_wrow;
        s_wdata = '0;
        if (r_state == ST_INIT) begin
            s_we    = 1'b1;
            s_waddr = r_cnt[AW-1:0];
        end else if ((r_state == ST_SWEEP && r_cnt != '0) || r_state == ST_LAST) begin
            s_we = 1'b1;
            if (r_cmd.func == bsd_pkg::OP_CLEAR) begin
                s_wdata = '0;
            end else if (r_set) begin
                s_wdata = r_rdata | r_mask;
            end else begin
                s_wdata = r_rdata & ~r_mask;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_INIT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(bsd_pkg::CANVAS_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_cnt = '0;
                if (start) begin
                    n_state = (i_func == bsd_pkg::OP_READ) ? ST_RD : ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(bsd_pkg::CANVAS_ROWS - 1)) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST:  n_state = ST_IDLE;
            ST_RD:    n_state = ST_RD2;
            ST_RD2:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= (r_state == ST_LAST) || (r_state == ST_RD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_cmd <= '{func: i_func, pos_row: i_pos_row, pos_col: i_pos_col,
                       arg_a: i_arg_a, arg_b: i_arg_b};
        end
        r_mask <= s_mask;
        r_set  <= s_set;
        r_wrow <= r_cnt[AW-1:0];
        if (r_state == ST_IDLE) begin
            r_dy2 <= 14'(($signed(9'd0) - $signed(9'(i_pos_row)))
                         * ($signed(9'd0) - $signed(9'(i_pos_row))));
        end else begin
            // squared row distance for the next row in the sweep
            r_dy2 <= 14'((s_dy + 9'sd1) * (s_dy + 9'sd1));
        end
        r_done_op <= r_cmd.func;
        r_pix     <= (r_state == ST_RD) ? 32'(r_rdata) : 32'd0;
    end

    assign o_done       = r_done;
    assign o_done_op    = r_done_op;
    assign o_row_pixels = r_pix;

    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");
    a_pix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_done_op != bsd_pkg::OP_READ) |-> o_row_pixels == 32'd0)
        else $error("pixels on non-read result");
endmodule

// ===== tb/bsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_checker
// tracks the canvas from accepted requests and checks every completion
// ----------------------------------------------------------------------------
module bsd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_func,
    input  logic [4:0]  i_pos_row,
    input  logic [4:0]  i_pos_col,
    input  logic [5:0]  i_arg_a,
    input  logic [5:0]  i_arg_b,
    input  logic        i_done,
    input  logic [2:0]  i_done_op,
    input  logic [31:0] i_row_pixels,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [2:0]  op;
        logic [31:0] pix;
    } t_done_exp;

    logic [31:0] canvas [32];
    t_done_exp   done_q [$];

    function automatic void plot(input int r, input int c, input bit on);
        if (r >= 0 && r < 32 && c >= 0 && c < 32) begin
            canvas[r][c] = on;
        end
    endfunction

    function automatic logic [31:0] apply_request(input logic [2:0] f, input int r,
                                                  input int c, input int a, input int b);
        int i, j, lo, hi, d;
        logic [31:0] pix;
        pix = '0;
        case (f)
            bsd_pkg::OP_CLEAR: begin
                for (i = 0; i < 32; i++) canvas[i] = '0;
            end
            bsd_pkg::OP_RECT: begin
                if (a != 0 && b != 0) begin
                    for (i = c; i < c + b; i++) begin
                        plot(r, i, 1);
                        plot(r + a - 1, i, 1);
                    end
                    for (i = r; i < r + a; i++) begin
                        plot(i, c, 1);
                        plot(i, c + b - 1, 1);
                    end
                end
            end
            bsd_pkg::OP_LINE: begin
                if (r == a) begin
                    lo = (c < b) ? c : b;
                    hi = (c < b) ? b : c;
                    for (i = lo; i <= hi; i++) plot(r, i, 1);
                end else if (c == b) begin
                    lo = (r < a) ? r : a;
                    hi = (r < a) ? a : r;
                    for (i = lo; i <= hi; i++) plot(i, c, 1);
                end
            end
            bsd_pkg::OP_TRI: begin
                if (a != 0) begin
                    for (i = 0; i < a; i++) begin
                        plot(r + i, c - i, 1);
                        plot(r + i, c + i, 1);
                    end
                    for (i = c - a + 1; i <= c + a - 1; i++) plot(r + a - 1, i, 1);
                end
            end
            bsd_pkg::OP_ERECT: begin
                for (i = r; i < r + a; i++)
                    for (j = c; j < c + b; j++) plot(i, j, 0);
            end
            bsd_pkg::OP_DISC, bsd_pkg::OP_EDISC: begin
                for (i = 0; i < 32; i++) begin
                    for (j = 0; j < 32; j++) begin
                        d = (j - c) * (j - c) + (i - r) * (i - r);
                        if (f == bsd_pkg::OP_DISC && d < a * a) plot(i, j, 1);
                        if (f == bsd_pkg::OP_EDISC && d <= a * a) plot(i, j, 0);
                    end
                end
            end
            default: pix = canvas[r];
        endcase
        return pix;
    endfunction

    always @(posedge i_clk) begin
        t_done_exp e;
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) canvas[i] = '0;
            done_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_done) begin
                if (done_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected completion op=%0d pix=%h", i_done_op, i_row_pixels);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = done_q.pop_front();
                    if (e.op !== i_done_op || e.pix !== i_row_pixels) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp op=%0d pix=%h, got op=%0d pix=%h",
                                     e.op, e.pix, i_done_op, i_row_pixels);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                e.op  = i_func;
                e.pix = apply_request(i_func, i_pos_row, i_pos_col, i_arg_a, i_arg_b);
                done_q.push_back(e);
            end
            o_pending <= done_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random draw requests into the engine, checker judges
// ----------------------------------------------------------------------------
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_func;
    logic [4:0]  i_pos_row;
    logic [4:0]  i_pos_col;
    logic [5:0]  i_arg_a;
    logic [5:0]  i_arg_b;
    logic        o_done;
    logic [2:0]  o_done_op;
    logic [31:0] o_row_pixels;
    int          fail_count;
    int          pending;
    int          idle_pct;

    bitmap_shape_draw_engine_top i_dut (.*);

    bsd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_func(i_func), .i_pos_row(i_pos_row), .i_pos_col(i_pos_col),
        .i_arg_a(i_arg_a), .i_arg_b(i_arg_b), .i_done(o_done),
        .i_done_op(o_done_op), .i_row_pixels(o_row_pixels),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the engine hangs
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // one request: optional idle gap, then hold start until the engine takes it
    task automatic send_request(input logic [2:0] f, input int r, input int c,
                                input int a, input int b);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        i_func    = f;
        i_pos_row = 5'(r);
        i_pos_col = 5'(c);
        i_arg_a   = 6'(a);
        i_arg_b   = 6'(b);
        start     = 1'b1;
        // busy is stable at the falling edge, so the next rising edge accepts
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic random_request();
        logic [2:0] f;
        int r, c, a, b;
        f = 3'($urandom_range(7));
        // keep full clears rare so the canvas builds up between reads
        if (f == bsd_pkg::OP_CLEAR && $urandom_range(3) != 0) f = bsd_pkg::OP_READ;
        r = $urandom_range(31);
        c = $urandom_range(31);
        a = ($urandom_range(99) < 75) ? $urandom_range(12) : $urandom_range(63);
        b = ($urandom_range(99) < 75) ? $urandom_range(12) : $urandom_range(63);
        if (f == bsd_pkg::OP_LINE) begin
            // mostly straight lines, some diagonal ones that draw nothing
            case ($urandom_range(4))
                0, 1: a = r;
                2, 3: b = c;
                default: ;
            endcase
        end
        send_request(f, r, c, a, b);
    endtask

    initial begin
        int phase_pct [3];
        start     = 1'b0;
        i_func    = bsd_pkg::OP_CLEAR;
        i_pos_row = '0;
        i_pos_col = '0;
        i_arg_a   = '0;
        i_arg_b   = '0;
        i_rst_n   = 1'b0;
        idle_pct  = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, every command, clipping and degenerate shapes
        send_request(bsd_pkg::OP_READ,   0,  0,  0,  0);
        send_request(bsd_pkg::OP_RECT,   0,  0, 63, 63);
        send_request(bsd_pkg::OP_READ,   0,  0,  0,  0);
        send_request(bsd_pkg::OP_READ,  31,  0,  0,  0);
        send_request(bsd_pkg::OP_CLEAR, 31, 31, 63, 63);
        send_request(bsd_pkg::OP_RECT,  31, 31,  1,  1);
        send_request(bsd_pkg::OP_RECT,   5,  5,  0,  7);
        send_request(bsd_pkg::OP_RECT,   5,  5,  7,  0);
        send_request(bsd_pkg::OP_LINE,   3,  2,  3, 40);
        send_request(bsd_pkg::OP_LINE,   2,  9, 60,  9);
        send_request(bsd_pkg::OP_LINE,   4,  4,  9,  9);
        send_request(bsd_pkg::OP_LINE,  20, 20, 20, 20);
        send_request(bsd_pkg::OP_TRI,   10, 10,  0,  0);
        send_request(bsd_pkg::OP_TRI,   31,  0, 63,  0);
        send_request(bsd_pkg::OP_TRI,    0, 16, 12,  0);
        send_request(bsd_pkg::OP_READ,  11,  0,  0,  0);
        send_request(bsd_pkg::OP_DISC,  16, 16,  0,  0);
        send_request(bsd_pkg::OP_DISC,  16, 16,  6,  0);
        send_request(bsd_pkg::OP_READ,  16,  0,  0,  0);
        send_request(bsd_pkg::OP_EDISC, 16, 16,  3,  0);
        send_request(bsd_pkg::OP_READ,  16,  0,  0,  0);
        send_request(bsd_pkg::OP_ERECT,  0,  0,  0, 63);
        send_request(bsd_pkg::OP_ERECT,  0,  0, 63,  0);
        send_request(bsd_pkg::OP_ERECT, 14, 14, 63, 63);
        send_request(bsd_pkg::OP_READ,  20,  0,  0,  0);

        // random: sender gaps 22%, then 84%, then none
        phase_pct = '{22, 84, 0};
        for (int p = 0; p < 3; p++) begin
            idle_pct = phase_pct[p];
            repeat (560) random_request();
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
